[hdl/assert_macros.svh]
// Assertion macros for the RTL of the shortest-queue dispatcher.
// No dependencies; the assertions compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked property check, disabled while the active-low reset is asserted.
`define ASSERT_CLK(label, clk, rstn, prop) \
	label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
		else $error("%m: assertion failed");
// Condition that must never hold at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rstn, cond) \
	`ASSERT_CLK(label, clk, rstn, !(cond))
`else
`define ASSERT_CLK(label, clk, rstn, prop)
`define ASSERT_NEVER(label, clk, rstn, cond)
`endif
`endif

[hdl/sqd_pkg.sv]
`timescale 1ns / 1ps
// Package for the shortest-queue dispatcher: field widths, request and
// status codes, parameter defaults. No dependencies.
package sqd_pkg;

	localparam int TAG_W    = 32;
	localparam int LINE_W   = 2;
	localparam int STATUS_W = 2;

	localparam int NUM_LINES_DEF  = 3;
	localparam int LINE_DEPTH_DEF = 16;

	typedef logic [STATUS_W-1:0] status_t;

	// Result status codes.
	localparam status_t ST_OK      = 2'd0;
	localparam status_t ST_EMPTY   = 2'd1;
	localparam status_t ST_FULL    = 2'd2;
	localparam status_t ST_BADLINE = 2'd3;

	// Request codes.
	localparam logic REQ_ADD   = 1'b0;
	localparam logic REQ_SERVE = 1'b1;

endpackage

[hdl/sqd_req_if.sv]
`timescale 1ns / 1ps
// Request channel of the shortest-queue dispatcher: valid/ready plus the
// request word. Depends on sqd_pkg.
interface sqd_req_if;
	logic                      valid;
	logic                      ready;
	logic                      req_type;
	logic [sqd_pkg::TAG_W-1:0]  customer_tag;
	logic [sqd_pkg::LINE_W-1:0] line_index;

	modport source (output valid, output req_type, output customer_tag,
		output line_index, input ready);
	modport sink (input valid, input req_type, input customer_tag,
		input line_index, output ready);
endinterface

[hdl/sqd_rsp_if.sv]
`timescale 1ns / 1ps
// Result channel of the shortest-queue dispatcher: valid/ready plus the
// result word. Depends on sqd_pkg.
interface sqd_rsp_if;
	logic                       valid;
	logic                       ready;
	sqd_pkg::status_t           result_status;
	logic [sqd_pkg::LINE_W-1:0] line_used;
	logic [sqd_pkg::TAG_W-1:0]  served_tag;

	modport source (output valid, output result_status, output line_used,
		output served_tag, input ready);
	modport sink (input valid, input result_status, input line_used,
		input served_tag, output ready);
endinterface

[hdl/shortest_queue_dispatch_fifos.sv]
`timescale 1ns / 1ps
// Shortest-queue dispatcher over NUM_LINES circular FIFOs of tag words.
// Depends on sqd_pkg, sqd_req_if, sqd_rsp_if and assert_macros.svh.
//
// Usage:
//   req carries one request word: an add (req_type 0) puts customer_tag
//   into the line with the fewest entries, lowest line on a tie; a serve
//   (req_type 1) pops the oldest tag of line line_index.
//   rsp carries exactly one result word per request, in request order:
//   status (ok, line empty, all lines full, bad line), the line used and
//   the served tag (zero unless a serve succeeded).
// Timing:
//   The decision, the counter update and the tag store access happen in
//   the cycle a request is accepted; the store read data and the status
//   land in stage 1 and move to the output register once that is free.
//   One request per cycle is taken while rsp.ready stays high.
// Stall:
//   Stage 1 and the output register hold one result each, so one more
//   request is taken while a result waits; after that req.ready drops
//   until rsp.ready returns.
// Reset:
//   arst_n clears all pointers, counts and valid flags at once; no
//   clearing pass is needed, the tag store itself is not cleared.
module shortest_queue_dispatch_fifos #(
	parameter int NUM_LINES  = sqd_pkg::NUM_LINES_DEF,
	parameter int LINE_DEPTH = sqd_pkg::LINE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	sqd_req_if.sink   req,
	sqd_rsp_if.source rsp
);

`include "assert_macros.svh"

	localparam int LIDX_W    = $clog2(NUM_LINES);
	localparam int PTR_W     = $clog2(LINE_DEPTH);
	localparam int OCC_W     = $clog2(LINE_DEPTH + 1);
	localparam int MEM_DEPTH = NUM_LINES * LINE_DEPTH;
	localparam int ADDR_W    = $clog2(MEM_DEPTH);

	localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(LINE_DEPTH - 1);
	localparam logic [OCC_W-1:0]  OCC_FULL = OCC_W'(LINE_DEPTH);
	localparam logic [ADDR_W-1:0] DEPTH_A  = ADDR_W'(LINE_DEPTH);
	localparam logic [sqd_pkg::LINE_W:0] NUM_LINES_X =
		(sqd_pkg::LINE_W + 1)'(NUM_LINES);

	// Per-line FIFO state.
	logic [PTR_W-1:0] wr_ptr_q [NUM_LINES];
	logic [PTR_W-1:0] rd_ptr_q [NUM_LINES];
	logic [OCC_W-1:0] occ_q    [NUM_LINES];

	// Tag store, one row of LINE_DEPTH words per line.
	logic [sqd_pkg::TAG_W-1:0] mem [MEM_DEPTH];

	// Stage 1 and output register.
	logic                        valid_s1;
	sqd_pkg::status_t            status_s1;
	logic [sqd_pkg::LINE_W-1:0]  line_s1;
	logic                        serve_ok_s1;
	logic [sqd_pkg::TAG_W-1:0]   rd_data_s1;
	logic                        out_valid_q;
	sqd_pkg::status_t            status_q;
	logic [sqd_pkg::LINE_W-1:0]  line_q;
	logic [sqd_pkg::TAG_W-1:0]   tag_q;

	logic                        acc;
	logic                        adv;
	logic                        is_add;
	logic [LIDX_W-1:0]           best;
	logic [LIDX_W-1:0]           sidx;
	logic                        all_full;
	logic                        bad_line;
	logic                        line_empty;
	logic                        do_write;
	logic                        do_read;
	sqd_pkg::status_t            status_d;
	logic [sqd_pkg::LINE_W-1:0]  line_d;
	logic [ADDR_W-1:0]           waddr;
	logic [ADDR_W-1:0]           raddr;

	// Handshake: stage 1 frees up whenever it moves on to the output.
	assign adv       = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || adv;
	assign acc       = req.valid && req.ready;
	assign is_add    = (req.req_type == sqd_pkg::REQ_ADD);

	// Pick the least occupied line; strict compare keeps the lowest on a tie.
	always_comb begin
		best = '0;
		for (int i = 1; i < NUM_LINES; i++) begin
			if (occ_q[i] < occ_q[best]) begin
				best = LIDX_W'(i);
			end
		end
	end

	// Decode the request against the current counts.
	assign sidx       = req.line_index[LIDX_W-1:0];
	assign all_full   = (occ_q[best] >= OCC_FULL);
	assign bad_line   = ({1'b0, req.line_index} >= NUM_LINES_X);
	assign line_empty = (occ_q[sidx] == '0);
	assign do_write   = acc && is_add && !all_full;
	assign do_read    = acc && !is_add && !bad_line && !line_empty;

	always_comb begin
		if (is_add) begin
			status_d = all_full ? sqd_pkg::ST_FULL : sqd_pkg::ST_OK;
			line_d   = all_full ? '0 : sqd_pkg::LINE_W'(best);
		end else begin
			line_d = req.line_index;
			if (bad_line) begin
				status_d = sqd_pkg::ST_BADLINE;
			end else if (line_empty) begin
				status_d = sqd_pkg::ST_EMPTY;
			end else begin
				status_d = sqd_pkg::ST_OK;
			end
		end
	end

	// Store addresses: row of the line plus the slot within it.
	assign waddr = ADDR_W'(ADDR_W'(best) * DEPTH_A + ADDR_W'(wr_ptr_q[best]));
	assign raddr = ADDR_W'(ADDR_W'(sidx) * DEPTH_A + ADDR_W'(rd_ptr_q[sidx]));

	// Pointer and count update; an item touches at most one line.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LINES; i++) begin
				wr_ptr_q[i] <= '0;
				rd_ptr_q[i] <= '0;
				occ_q[i]    <= '0;
			end
		end else begin
			for (int i = 0; i < NUM_LINES; i++) begin
				if (do_write && (best == LIDX_W'(i))) begin
					wr_ptr_q[i] <= (wr_ptr_q[i] == PTR_LAST) ? '0 : wr_ptr_q[i] + 1'b1;
					occ_q[i]    <= occ_q[i] + 1'b1;
				end
				if (do_read && (sidx == LIDX_W'(i))) begin
					rd_ptr_q[i] <= (rd_ptr_q[i] == PTR_LAST) ? '0 : rd_ptr_q[i] + 1'b1;
					occ_q[i]    <= occ_q[i] - 1'b1;
				end
			end
		end
	end

	// Tag store with a registered read port.
	always_ff @(posedge clk) begin
		if (do_write) begin
			mem[waddr] <= req.customer_tag;
		end
		if (do_read) begin
			rd_data_s1 <= mem[raddr];
		end
	end

	// Valid flags of stage 1 and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload; the served tag is zero unless a serve succeeded.
	always_ff @(posedge clk) begin
		if (acc) begin
			status_s1   <= status_d;
			line_s1     <= line_d;
			serve_ok_s1 <= do_read;
		end
		if (adv) begin
			status_q <= status_s1;
			line_q   <= line_s1;
			tag_q    <= serve_ok_s1 ? rd_data_s1 : '0;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.result_status = status_q;
	assign rsp.line_used     = line_q;
	assign rsp.served_tag    = tag_q;

	// Checks on the counters and the result path.
	for (genvar g = 0; g < NUM_LINES; g++) begin : g_chk
		`ASSERT_CLK(a_occ_bound, clk, arst_n, occ_q[g] <= OCC_FULL)
	end
	`ASSERT_CLK(a_s1_hold, clk, arst_n, (valid_s1 && out_valid_q && !rsp.ready) |=> valid_s1)
	`ASSERT_NEVER(a_tag_zero, clk, arst_n, out_valid_q && (status_q != sqd_pkg::ST_OK) && (tag_q != '0))
	`ASSERT_NEVER(a_rw_excl, clk, arst_n, do_write && do_read)

endmodule
